// ===== src/font_cmap_glyph_lookup_macros.svh =====
// Assertion macros for the port-level checker file.
`ifndef FONT_CMAP_GLYPH_LOOKUP_MACROS_SVH
`define FONT_CMAP_GLYPH_LOOKUP_MACROS_SVH
// Assert that a condition implies a condition in the next cycle.
`define FCG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
// Assert that a condition implies a condition in the same cycle.
`define FCG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`endif

// ===== src/fcg_pkg.sv =====
// Package with the item types, constants and command and status structs of the glyph lookup.
`timescale 1ns / 1ps
package fcg_pkg;
    localparam int MEM_BYTES_DEF = 65536;
    localparam logic [20:0] PUA_MASK = 21'h00F000;
    localparam logic [15:0] LOW16_MASK = 16'hffff;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;
    localparam logic CFG_OFFSET = 1'b0;
    localparam logic CFG_PUA = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [15:0] byte_address;
        logic [7:0]  byte_value;
        logic [20:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] glyph_id;
        logic               unknown_format;
        logic               out_of_range;
    } out_item_t;

    // Datapath commands from the controller.
    typedef struct packed {
        logic        rd_start;   // read rd_len bytes at rd_addr into the accumulator
        logic [32:0] rd_addr;
        logic [2:0]  rd_len;
    } fcg_cmd_t;

    // Datapath status to the controller.
    typedef struct packed {
        logic        rd_done;
        logic        rd_fault;
        logic [31:0] rd_data;
    } fcg_sts_t;
endpackage

// ===== src/font_cmap_glyph_lookup.sv =====
// Top level of the cmap character-to-glyph lookup.
// Load item: written into font memory when taken, no result. Lookup item: a
// walk of big-endian field reads through the single byte port of the font
// memory, their number set by the segment or group a code falls in.
// One item at a time. rst_n clears control state; font memory is not cleared.
`timescale 1ns / 1ps
module font_cmap_glyph_lookup
    import fcg_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    logic        busy_reg, busy_next;
    logic        ovalid_reg, ovalid_next;
    out_item_t   odata_reg;
    logic [15:0] offset_reg;
    logic        pua_reg;
    logic        start, done, acc;
    fcg_cmd_t    cmd;
    fcg_sts_t    sts;
    out_item_t   result;

    // Hold off while a lookup runs or its result is not yet taken.
    assign in_stall = busy_reg || ovalid_reg;
    assign acc = in_valid && !in_stall;
    assign start = acc && (in_data.operation == OP_LOOKUP);

    always_comb
    begin
        busy_next = busy_reg;
        ovalid_next = ovalid_reg;
        if (start)
            busy_next = 1'b1;
        if (done)
        begin
            busy_next = 1'b0;
            ovalid_next = 1'b1;
        end
        else if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            offset_reg <= '0;
            pua_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we && cfg_index == CFG_OFFSET)
                offset_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_PUA)
                pua_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
            odata_reg <= result;
    end

    fcg_datapath #(.MEM_BYTES(MEM_BYTES)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (acc && in_data.operation == OP_LOAD),
        .wr_addr (in_data.byte_address),
        .wr_data (in_data.byte_value),
        .cmd     (cmd),
        .sts     (sts)
    );

    fcg_controller u_ctl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .code_in (in_data.char_code),
        .offset  (offset_reg),
        .pua_en  (pua_reg),
        .sts     (sts),
        .cmd     (cmd),
        .done    (done),
        .result  (result)
    );

    assign out_valid = ovalid_reg;
    assign out_data = odata_reg;
endmodule

// ===== src/fcg_datapath.sv =====
// Font byte memory with a byte-serial big-endian field reader.
`timescale 1ns / 1ps
module fcg_datapath
    import fcg_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF,
    localparam int AW = $clog2(MEM_BYTES)
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [15:0] wr_addr,
    input  logic [7:0]  wr_data,
    input  fcg_cmd_t    cmd,
    output fcg_sts_t    sts
);
    logic [7:0]  mem [MEM_BYTES];
    logic [7:0]  rdata_reg;
    logic [32:0] addr_reg, addr_next;
    logic [2:0]  left_reg, left_next;
    logic        busy_reg, busy_next;
    logic        pend_reg, pend_next;
    logic        done_reg, done_next;
    logic        fault_reg, fault_next;
    logic [31:0] acc_reg, acc_next;
    logic        in_mem;

    // Write loads; read one byte a cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en && ({1'b0, wr_addr} < 17'(MEM_BYTES)))
            mem[wr_addr[AW-1:0]] <= wr_data;
        rdata_reg <= mem[addr_reg[AW-1:0]];
    end

    // Check a whole field fits before reading it.
    always_comb
    begin
        in_mem = (cmd.rd_addr + 33'(cmd.rd_len)) <= 33'(MEM_BYTES);
    end

    // Step the byte reader.
    always_comb
    begin
        addr_next = addr_reg;
        left_next = left_reg;
        busy_next = busy_reg;
        pend_next = 1'b0;
        done_next = 1'b0;
        fault_next = fault_reg;
        acc_next = acc_reg;
        if (pend_reg)
            acc_next = {acc_reg[23:0], rdata_reg};
        if (cmd.rd_start)
        begin
            acc_next = '0;
            fault_next = !in_mem;
            addr_next = cmd.rd_addr;
            left_next = cmd.rd_len;
            busy_next = in_mem;
            done_next = !in_mem;
        end
        else if (busy_reg)
        begin
            if (left_reg != 3'd0)
            begin
                pend_next = 1'b1;
                addr_next = addr_reg + 33'd1;
                left_next = left_reg - 3'd1;
            end
            else if (!pend_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
            fault_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pend_reg <= pend_next;
            done_reg <= done_next;
            fault_reg <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        left_reg <= left_next;
        acc_reg <= acc_next;
    end

    assign sts.rd_done = done_reg;
    assign sts.rd_fault = fault_reg;
    assign sts.rd_data = acc_reg;
endmodule

// ===== src/fcg_controller.sv =====
// Lookup sequencer that walks the cmap subtable formats through field reads.
`timescale 1ns / 1ps
module fcg_controller
    import fcg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [20:0] code_in,
    input  logic [15:0] offset,
    input  logic        pua_en,
    input  fcg_sts_t    sts,
    output fcg_cmd_t    cmd,
    output logic        done,
    output out_item_t   result
);
    localparam logic [4:0] S_IDLE = 5'd0, S_FMT = 5'd1, S_F0 = 5'd2, S_SEG = 5'd3,
        S_START = 5'd4, S_END = 5'd5, S_DELTA = 5'd6, S_ROFF = 5'd7, S_GLY = 5'd8,
        S_F6A = 5'd9, S_F6B = 5'd10, S_F6G = 5'd11, S_NGRP = 5'd12, S_GS = 5'd13,
        S_GE = 5'd14, S_GSG = 5'd15, S_FIN = 5'd16, S_ISSUE = 5'd17;

    logic [4:0]  state_reg, state_next;
    logic [4:0]  ret_reg, ret_next;      // state that takes the pending read
    logic [32:0] raddr_reg, raddr_next;
    logic [2:0]  rlen_reg, rlen_next;
    logic [20:0] code_reg, code_next;
    logic [20:0] orig_reg, orig_next;
    logic        retry_reg, retry_next;
    logic        f1_reg, f1_next;
    logic        bad_reg, bad_next;
    logic [31:0] gid_reg, gid_next;
    logic        fin_reg, fin_next;
    logic [15:0] fmt_reg, fmt_next;
    logic [31:0] a_reg, a_next;          // seg2 / first / group count
    logic [31:0] b_reg, b_next;          // segment index
    logic [31:0] c_reg, c_next;          // segment start / group start
    logic [31:0] d_reg, d_next;          // delta / group end
    logic        done_reg, done_next;
    out_item_t   res_reg, res_next;
    logic [32:0] t;
    logic [32:0] ends_a, starts_a, deltas_a, roffs_a, code33;
    logic [31:0] rd;

    assign t = {17'd0, offset};
    assign ends_a = t + 33'd14;
    assign starts_a = ends_a + {17'd0, a_reg[15:0]} + 33'd2;
    assign deltas_a = starts_a + {17'd0, a_reg[15:0]};
    assign roffs_a = deltas_a + {17'd0, a_reg[15:0]};
    assign code33 = {12'd0, code_reg};
    assign rd = sts.rd_data;

    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        raddr_next = raddr_reg;
        rlen_next = rlen_reg;
        code_next = code_reg;
        orig_next = orig_reg;
        retry_next = retry_reg;
        f1_next = f1_reg;
        bad_next = bad_reg;
        gid_next = gid_reg;
        fin_next = 1'b0;
        fmt_next = fmt_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        done_next = 1'b0;
        res_next = res_reg;
        cmd.rd_start = 1'b0;
        cmd.rd_addr = raddr_reg;
        cmd.rd_len = rlen_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    code_next = code_in;
                    orig_next = code_in;
                    retry_next = 1'b0;
                    f1_next = 1'b0;
                    bad_next = 1'b0;
                    // Identity when no subtable is selected.
                    if (offset == 16'd0)
                    begin
                        gid_next = {11'd0, code_in};
                        state_next = S_FIN;
                    end
                    else
                    begin
                        raddr_next = t;
                        rlen_next = 3'd2;
                        ret_next = S_FMT;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE:
            begin
                cmd.rd_start = 1'b1;
                state_next = ret_reg;
            end
            S_FIN:
            begin
                // Retry in the private area once on a zero result.
                if (gid_reg == 32'd0 && pua_en && !retry_reg)
                begin
                    retry_next = 1'b1;
                    f1_next = sts.rd_fault && fin_reg;
                    code_next = orig_reg | PUA_MASK;
                    if (offset == 16'd0)
                        gid_next = {11'd0, orig_reg | PUA_MASK};
                    else
                    begin
                        raddr_next = t;
                        rlen_next = 3'd2;
                        ret_next = S_FMT;
                        state_next = S_ISSUE;
                    end
                end
                else
                begin
                    res_next.glyph_id = gid_reg;
                    res_next.unknown_format = bad_reg;
                    res_next.out_of_range = f1_reg || (sts.rd_fault && fin_reg);
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                if (sts.rd_done)
                begin
                    fin_next = 1'b1;
                    gid_next = 32'd0;
                    state_next = S_FIN;
                    if (!sts.rd_fault)
                    begin
                        state_next = S_ISSUE;
                        case (state_reg)
                            S_FMT:
                            begin
                                fmt_next = rd[15:0];
                                state_next = S_FIN;
                                fin_next = 1'b0;
                                if (rd[15:0] == 16'd0)
                                begin
                                    if (code_reg <= 21'd255)
                                    begin
                                        raddr_next = t + 33'd6 + code33;
                                        rlen_next = 3'd1;
                                        ret_next = S_F0;
                                        state_next = S_ISSUE;
                                    end
                                end
                                else if (rd[15:0] == 16'd4 || rd[15:0] == 16'd6)
                                begin
                                    raddr_next = t + 33'd6;
                                    rlen_next = 3'd2;
                                    ret_next = (rd[15:0] == 16'd4) ? S_SEG : S_F6A;
                                    state_next = S_ISSUE;
                                end
                                else if (rd[15:0] == 16'd10)
                                begin
                                    raddr_next = t + 33'd12;
                                    rlen_next = 3'd4;
                                    ret_next = S_F6A;
                                    state_next = S_ISSUE;
                                end
                                else if (rd[15:0] == 16'd12)
                                begin
                                    raddr_next = t + 33'd12;
                                    rlen_next = 3'd4;
                                    ret_next = S_NGRP;
                                    state_next = S_ISSUE;
                                end
                                else
                                    bad_next = 1'b1;
                            end
                            S_F0:
                            begin
                                gid_next = rd;
                                state_next = S_FIN;
                            end
                            S_SEG:
                            begin
                                a_next = rd;
                                b_next = 32'd0;
                                if (rd[15:0] > 16'd3)
                                begin
                                    raddr_next = t + 33'd14 + {17'd0, rd[15:0]} + 33'd2;
                                    rlen_next = 3'd2;
                                    ret_next = S_START;
                                end
                                else
                                    state_next = S_FIN;
                            end
                            S_START:
                            begin
                                c_next = rd;
                                if (code_reg < rd[20:0] || rd[31:21] != 11'd0)
                                    state_next = S_FIN;
                                else
                                begin
                                    raddr_next = ends_a + b_reg[32:0];
                                    ret_next = S_END;
                                end
                            end
                            S_END:
                            begin
                                if (code33 > {1'b0, rd})
                                begin
                                    b_next = b_reg + 32'd2;
                                    if (b_reg + 32'd5 < a_reg)
                                    begin
                                        raddr_next = starts_a + b_reg[32:0] + 33'd2;
                                        ret_next = S_START;
                                    end
                                    else
                                        state_next = S_FIN;
                                end
                                else
                                begin
                                    raddr_next = deltas_a + b_reg[32:0];
                                    ret_next = S_DELTA;
                                end
                            end
                            S_DELTA:
                            begin
                                d_next = rd;
                                raddr_next = roffs_a + b_reg[32:0];
                                ret_next = S_ROFF;
                            end
                            S_ROFF:
                            begin
                                if (rd[15:0] == 16'd0)
                                begin
                                    gid_next = {16'd0, code_reg[15:0] + d_reg[15:0]};
                                    state_next = S_FIN;
                                end
                                else
                                begin
                                    raddr_next = roffs_a + b_reg[32:0] + {17'd0, rd[15:0]}
                                        + {(code33 - {1'b0, c_reg}), 1'b0}[32:0];
                                    ret_next = S_GLY;
                                end
                            end
                            S_GLY:
                            begin
                                state_next = S_FIN;
                                if (fmt_reg == 16'd4)
                                begin
                                    if (rd[15:0] != 16'd0)
                                        gid_next = {16'd0, rd[15:0] + d_reg[15:0]};
                                end
                                else
                                    gid_next = rd;
                            end
                            S_F6A:
                            begin
                                a_next = rd;
                                raddr_next = raddr_reg + 33'(rlen_reg);
                                ret_next = S_F6B;
                            end
                            S_F6B:
                            begin
                                if (code33 < {1'b0, a_reg}
                                    || {1'b0, code33} >= {1'b0, a_reg} + {1'b0, rd})
                                    state_next = S_FIN;
                                else
                                begin
                                    raddr_next = raddr_reg + 33'(rlen_reg)
                                        + {(code33 - {1'b0, a_reg}), 1'b0}[32:0];
                                    rlen_next = 3'd2;
                                    ret_next = S_GLY;
                                end
                            end
                            S_NGRP:
                            begin
                                a_next = rd;
                                if (rd == 32'd0)
                                    state_next = S_FIN;
                                else
                                begin
                                    raddr_next = t + 33'd16;
                                    ret_next = S_GS;
                                end
                            end
                            S_GS:
                            begin
                                c_next = rd;
                                raddr_next = raddr_reg + 33'd4;
                                ret_next = S_GE;
                            end
                            S_GE:
                            begin
                                d_next = rd;
                                raddr_next = raddr_reg + 33'd4;
                                ret_next = S_GSG;
                            end
                            S_GSG:
                            begin
                                if (code33 < {1'b0, c_reg})
                                    state_next = S_FIN;
                                else if (code33 <= {1'b0, d_reg})
                                begin
                                    gid_next = rd + code33[31:0] - c_reg;
                                    state_next = S_FIN;
                                end
                                else
                                begin
                                    a_next = a_reg - 32'd1;
                                    if (a_reg == 32'd1)
                                        state_next = S_FIN;
                                    else
                                    begin
                                        raddr_next = raddr_reg + 33'd4;
                                        ret_next = S_GS;
                                    end
                                end
                            end
                            default:
                                state_next = S_FIN;
                        endcase
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
            fin_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
            fin_reg <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg <= ret_next;
        raddr_reg <= raddr_next;
        rlen_reg <= rlen_next;
        code_reg <= code_next;
        orig_reg <= orig_next;
        retry_reg <= retry_next;
        f1_reg <= f1_next;
        bad_reg <= bad_next;
        gid_reg <= gid_next;
        fmt_reg <= fmt_next;
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign result = res_reg;
endmodule

// ===== src/fcg_checker.sv =====
// Port-level checker for the glyph lookup, bound to the top level.
`timescale 1ns / 1ps
`include "font_cmap_glyph_lookup_macros.svh"
module fcg_checker
    import fcg_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);
    `FCG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    `FCG_ASSERT_NOW(a_stall_on_result, out_valid, in_stall)
    `FCG_ASSERT_NEXT(a_lookup_stalls,
        in_valid && !in_stall && in_data.operation == OP_LOOKUP, in_stall)
    `FCG_ASSERT_NEXT(a_load_no_result,
        in_valid && !in_stall && in_data.operation == OP_LOAD && !out_valid, !out_valid)
endmodule

bind font_cmap_glyph_lookup fcg_checker u_chk (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the cmap glyph lookup: builds font tables, maps codes, checks glyphs.
`timescale 1ns / 1ps
module tb;
    import fcg_pkg::*;

    localparam int MEM_SIZE = 65536;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS = 1950;

    // subtable format numbers
    localparam int FMT_BYTE = 0;
    localparam int FMT_HIGHBYTE = 2;
    localparam int FMT_SEGMENT = 4;
    localparam int FMT_TRIMMED = 6;
    localparam int FMT_MIXED = 8;
    localparam int FMT_TRIMMED32 = 10;
    localparam int FMT_GROUPS = 12;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    font_cmap_glyph_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // font memory image and the set of bytes written so far
    logic [7:0] font_image [MEM_SIZE];
    bit         byte_known [MEM_SIZE];
    longint unsigned table_base;
    bit         retry_pua;
    bit         read_fault;
    bit         bad_format;
    bit         read_unknown;

    out_item_t  glyph_expect_q [$];
    int         err_count;
    int         n_loads;
    int         n_lookups;
    int         n_faults;
    int         n_unknown;
    int         items_sent;
    int         idle_pct;
    int         stall_pct;
    int         hold_left;
    int         quiet_cycles;

    // code windows of the current table, used to aim lookups
    longint unsigned win_lo [$];
    longint unsigned win_hi [$];

    always #5 clk = ~clk;

    // Fetch n big-endian bytes; flag reads past memory end or of unwritten bytes.
    function automatic longint unsigned fetch_be(longint unsigned addr, int n);
        longint unsigned v;
        int k;
        v = 0;
        if (read_fault || addr > longint'(MEM_SIZE - n)) begin
            read_fault = 1'b1;
            return 0;
        end
        for (k = 0; k < n; k++) begin
            if (!byte_known[addr + k])
                read_unknown = 1'b1;
            v = (v << 8) | font_image[addr + k];
        end
        return v;
    endfunction

    // Map one code through the selected subtable.
    function automatic longint unsigned map_code(longint unsigned code);
        longint unsigned t, fmt, seg2, ends, starts, deltas, roffs, i;
        longint unsigned st, en, dl, ro, g, first, cnt, groups, s, e, sg;
        t = table_base;
        if (t == 0)
            return code;
        fmt = fetch_be(t, 2);
        if (read_fault)
            return 0;
        case (fmt)
            FMT_BYTE:
            begin
                if (code > 255)
                    return 0;
                return fetch_be(t + 6 + code, 1);
            end
            FMT_SEGMENT:
            begin
                seg2 = fetch_be(t + 6, 2);
                ends = t + 14;
                starts = ends + seg2 + 2;
                deltas = starts + seg2;
                roffs = deltas + seg2;
                if (read_fault)
                    return 0;
                // the last segment is skipped on purpose
                for (i = 0; i + 3 < seg2; i += 2) begin
                    st = fetch_be(starts + i, 2);
                    if (read_fault || read_unknown || code < st)
                        return 0;
                    en = fetch_be(ends + i, 2);
                    if (read_fault)
                        return 0;
                    if (code > en)
                        continue;
                    dl = fetch_be(deltas + i, 2);
                    ro = fetch_be(roffs + i, 2);
                    if (read_fault)
                        return 0;
                    if (ro == 0)
                        return (code + dl) & 64'hFFFF;
                    g = fetch_be(roffs + i + ro + ((code - st) << 1), 2);
                    if (read_fault || g == 0)
                        return 0;
                    return (g + dl) & 64'hFFFF;
                end
                return 0;
            end
            FMT_TRIMMED:
            begin
                first = fetch_be(t + 6, 2);
                cnt = fetch_be(t + 8, 2);
                if (read_fault || code < first || code >= first + cnt)
                    return 0;
                return fetch_be(t + 10 + ((code - first) << 1), 2);
            end
            FMT_TRIMMED32:
            begin
                first = fetch_be(t + 12, 4);
                cnt = fetch_be(t + 16, 4);
                if (read_fault || code < first || code >= first + cnt)
                    return 0;
                return fetch_be(t + 20 + ((code - first) << 1), 2);
            end
            FMT_GROUPS:
            begin
                groups = fetch_be(t + 12, 4);
                g = t + 16;
                if (read_fault)
                    return 0;
                for (i = 0; i < groups; i++) begin
                    s = fetch_be(g, 4);
                    e = fetch_be(g + 4, 4);
                    sg = fetch_be(g + 8, 4);
                    if (read_fault || read_unknown || code < s)
                        return 0;
                    if (code <= e)
                        return (sg + (code - s)) & 64'hFFFF_FFFF;
                    g += 12;
                end
                return 0;
            end
            default:
            begin
                bad_format = 1'b1;
                return 0;
            end
        endcase
    endfunction

    // Predict a lookup result, with the private-use retry; ok is low if unwritten bytes are read.
    function automatic bit predict_glyph(logic [20:0] code, output out_item_t res);
        longint unsigned g;
        bit first_fault;
        read_fault = 1'b0;
        bad_format = 1'b0;
        read_unknown = 1'b0;
        g = map_code(code);
        if (g == 0 && retry_pua) begin
            first_fault = read_fault;
            read_fault = 1'b0;
            g = map_code(code | PUA_MASK);
            read_fault = read_fault | first_fault;
        end
        res.glyph_id = g[31:0];
        res.unknown_format = bad_format;
        res.out_of_range = read_fault;
        return !read_unknown;
    endfunction

    // Offer one item and hold it until taken.
    task automatic push_item(input in_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic load_byte(longint unsigned addr, logic [7:0] val);
        in_item_t it;
        // writes past the end are dropped so addresses never wrap
        if (addr >= MEM_SIZE)
            return;
        it.operation = OP_LOAD;
        it.byte_address = addr[15:0];
        it.byte_value = val;
        it.char_code = $urandom;
        font_image[addr] = val;
        byte_known[addr] = 1'b1;
        n_loads++;
        push_item(it);
    endtask

    task automatic load_be(longint unsigned addr, longint unsigned val, int n);
        int k;
        for (k = 0; k < n; k++)
            load_byte(addr + k, val >> (8 * (n - 1 - k)));
    endtask

    task automatic lookup_code(logic [20:0] code);
        in_item_t it;
        out_item_t res;
        // skip codes whose walk would touch bytes never written
        if (!predict_glyph(code, res))
            return;
        it.operation = OP_LOOKUP;
        it.byte_address = $urandom;
        it.byte_value = $urandom;
        it.char_code = code;
        glyph_expect_q.push_back(res);
        n_lookups++;
        n_faults += res.out_of_range;
        n_unknown += res.unknown_format;
        push_item(it);
    endtask

    // Drop valid and wait until the block is idle.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (glyph_expect_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] val);
        settle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_OFFSET)
            table_base = val;
        else
            retry_pua = val[0];
    endtask

    // Build a segment-mapped table with a few short segments.
    task automatic build_segments(longint unsigned t);
        int nseg, i, len;
        longint unsigned seg2, st, en, ga, goff, ro, base;
        nseg = $urandom_range(1, 6);
        seg2 = 2 * nseg;
        ga = t + 16 + 4 * seg2;
        goff = 0;
        base = ($urandom_range(3) == 0) ? 16'hF000 + $urandom_range(64) : $urandom_range(16'hE000);
        st = base;
        load_be(t, FMT_SEGMENT, 2);
        load_be(t + 6, seg2, 2);
        load_be(t + 14 + seg2, 0, 2);
        for (i = 0; i < nseg; i++) begin
            len = $urandom_range(7);
            en = st + len;
            if (i == nseg - 1 && $urandom_range(1)) begin
                st = 16'hFFFF;
                en = 16'hFFFF;
            end
            if (en > 16'hFFFF)
                en = 16'hFFFF;
            load_be(t + 14 + 2 * i, en, 2);
            load_be(t + 16 + seg2 + 2 * i, st, 2);
            load_be(t + 16 + 2 * seg2 + 2 * i, $urandom, 2);
            win_lo.push_back(st);
            win_hi.push_back(en);
            if ($urandom_range(1)) begin
                ro = 0;
            end else if ($urandom_range(7) == 0) begin
                ro = $urandom_range(16'hFFFF);
            end else begin
                ro = ga + goff - (t + 16 + 3 * seg2 + 2 * i);
                repeat (en - st + 1) begin
                    load_be(ga + goff, ($urandom_range(4) == 0) ? 0 : $urandom, 2);
                    goff += 2;
                end
            end
            load_be(t + 16 + 3 * seg2 + 2 * i, ro, 2);
            st = en + 1 + $urandom_range(20);
            if (st > 16'hFFF8)
                break;
        end
    endtask

    // Build a grouped table; the group count is sometimes overstated.
    task automatic build_groups(longint unsigned t);
        int ng, i;
        longint unsigned s, e, g;
        ng = $urandom_range(1, 8);
        s = ($urandom_range(3) == 0) ? 21'h00F000 + $urandom_range(32) : $urandom_range(21'h1F0000);
        load_be(t, FMT_GROUPS, 2);
        load_be(t + 12, ($urandom_range(5) == 0) ? ng + $urandom_range(1, 3) : ng, 4);
        g = t + 16;
        for (i = 0; i < ng; i++) begin
            e = s + $urandom_range(40);
            load_be(g, s, 4);
            load_be(g + 4, e, 4);
            load_be(g + 8, ($urandom_range(4) == 0) ? 32'hFFFF_FFF0 : $urandom, 4);
            win_lo.push_back(s);
            win_hi.push_back(e);
            s = e + 1 + $urandom_range(30);
            g += 12;
        end
    endtask

    task automatic build_trimmed(longint unsigned t, bit wide);
        longint unsigned first, cnt, gbase;
        int i;
        cnt = $urandom_range(1, 12);
        if (wide) begin
            first = $urandom_range(21'h1FFF00);
            load_be(t, FMT_TRIMMED32, 2);
            load_be(t + 12, first, 4);
            load_be(t + 16, cnt, 4);
            gbase = t + 20;
        end else begin
            first = ($urandom_range(3) == 0) ? 16'hF000 : $urandom_range(16'hFF00);
            load_be(t, FMT_TRIMMED, 2);
            load_be(t + 6, first, 2);
            load_be(t + 8, cnt, 2);
            gbase = t + 10;
        end
        for (i = 0; i < cnt; i++)
            load_be(gbase + 2 * i, $urandom, 2);
        win_lo.push_back(first);
        win_hi.push_back(first + cnt - 1);
    endtask

    // Pick a code near the current table's windows, or anywhere.
    function automatic logic [20:0] aim_code();
        int w;
        longint unsigned c;
        if (win_lo.size() == 0 || $urandom_range(5) == 0)
            return $urandom;
        w = $urandom_range(win_lo.size() - 1);
        c = win_lo[w] + $urandom_range(win_hi[w] - win_lo[w] + 4);
        c = (c >= 2) ? c - 2 : c;
        if ($urandom_range(9) == 0)
            c = c & ~longint'(PUA_MASK);
        return c[20:0];
    endfunction

    task automatic set_pace(int mode);
        settle();
        case (mode % 4)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 86; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 86; end
            default: begin idle_pct = 14; stall_pct = 14; end
        endcase
    endtask

    task automatic test_identity();
        load_byte(16'h0000, 8'hFF);
        load_byte(16'hFFFF, 8'h00);
        load_byte(16'h0000, 8'h00);
        load_byte(16'hFFFF, 8'hFF);
        write_cfg(CFG_OFFSET, 16'h0000);
        write_cfg(CFG_PUA, 1'b0);
        lookup_code(21'h000000);
        lookup_code(21'h1FFFFF);
        lookup_code(21'h0AAAAA);
        lookup_code(21'h155555);
        // a zero code retries into the private-use area
        write_cfg(CFG_PUA, 1'b1);
        lookup_code(21'h000000);
    endtask

    task automatic test_byte_format();
        longint unsigned t;
        int i;
        t = 16'h0100;
        load_be(t, FMT_BYTE, 2);
        for (i = 0; i < 256; i++)
            load_byte(t + 6 + i, ($urandom_range(7) == 0) ? 0 : $urandom);
        write_cfg(CFG_OFFSET, t);
        write_cfg(CFG_PUA, 1'b0);
        lookup_code(21'd0);
        lookup_code(21'd255);
        lookup_code(21'd256);
        write_cfg(CFG_PUA, 1'b1);
        lookup_code(21'd256);
        lookup_code($urandom_range(255));
    endtask

    task automatic test_unknown_formats();
        load_be(16'h0400, FMT_HIGHBYTE, 2);
        load_be(16'h0410, FMT_MIXED, 2);
        load_be(16'h0420, 16'h1234, 2);
        write_cfg(CFG_OFFSET, 16'h0400);
        lookup_code(21'h000041);
        write_cfg(CFG_OFFSET, 16'h0410);
        lookup_code(21'h000041);
        write_cfg(CFG_PUA, 1'b0);
        write_cfg(CFG_OFFSET, 16'h0420);
        lookup_code(21'h1FFFFF);
    endtask

    task automatic test_out_of_range();
        // no room for the format word
        write_cfg(CFG_OFFSET, 16'hFFFF);
        lookup_code(21'h000020);
        // format word fits, group count runs off the end
        load_be(16'hFFFE, FMT_GROUPS, 2);
        write_cfg(CFG_OFFSET, 16'hFFFE);
        lookup_code(21'h000020);
        write_cfg(CFG_PUA, 1'b1);
        lookup_code(21'h000020);
    endtask

    task automatic test_last_segment_skipped();
        win_lo.delete();
        win_hi.delete();
        write_cfg(CFG_PUA, 1'b0);
        build_segments(16'h0600);
        write_cfg(CFG_OFFSET, 16'h0600);
        lookup_code(win_lo[win_lo.size() - 1]);
        lookup_code(win_hi[win_hi.size() - 1]);
        lookup_code(win_lo[0]);
    endtask

    task automatic test_random_tables();
        int phase, n, kind;
        longint unsigned t;
        phase = 0;
        while (items_sent < RANDOM_ITEMS + 400) begin
            set_pace(phase);
            win_lo.delete();
            win_hi.delete();
            if ($urandom_range(5) == 0)
                t = 16'hFFFF - $urandom_range(60);
            else
                t = $urandom_range(16'h10, 16'hFE00);
            kind = $urandom_range(9);
            if (kind < 3)
                build_segments(t);
            else if (kind < 6)
                build_groups(t);
            else if (kind < 8)
                build_trimmed(t, kind == 7);
            else
                load_be(t, (kind == 8) ? FMT_MIXED : $urandom_range(13, 16'hFFFF), 2);
            write_cfg(CFG_OFFSET, ($urandom_range(15) == 0) ? 16'h0000 : t[15:0]);
            write_cfg(CFG_PUA, $urandom_range(1));
            n = $urandom_range(30, 60);
            repeat (n) begin
                // mostly lookups, some stray loads into the table
                if ($urandom_range(15) == 0)
                    load_byte(t + $urandom_range(40), $urandom);
                else
                    lookup_code(aim_code());
            end
            phase++;
        end
    endtask

    task automatic test_backpressure();
        set_pace(0);
        hold_left = 400;
        repeat (40)
            lookup_code(aim_code());
    endtask

    // Receiver stall, with a long hold-off on request.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each taken result with the oldest expectation.
    always @(posedge clk) begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (glyph_expect_q.size() == 0) begin
                $error("result with nothing expected: glyph_id %0d", out_data.glyph_id);
                err_count++;
            end else begin
                want = glyph_expect_q.pop_front();
                if (out_data.glyph_id !== want.glyph_id) begin
                    $error("glyph_id expected %0d got %0d", want.glyph_id, out_data.glyph_id);
                    err_count++;
                end
                if (out_data.unknown_format !== want.unknown_format) begin
                    $error("unknown_format expected %0d got %0d",
                           want.unknown_format, out_data.unknown_format);
                    err_count++;
                end
                if (out_data.out_of_range !== want.out_of_range) begin
                    $error("out_of_range expected %0d got %0d",
                           want.out_of_range, out_data.out_of_range);
                    err_count++;
                end
            end
        end
    end

    // End the run if nothing moves for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_OFFSET;
        cfg_data = '0;
        hold_left = 0;
        quiet_cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        table_base = 0;
        retry_pua = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_identity();
        test_byte_format();
        test_unknown_formats();
        test_out_of_range();
        test_last_segment_skipped();
        test_random_tables();
        test_backpressure();

        settle();
        $display("covered %0d font byte loads and %0d lookups over formats 0/4/6/10/12",
                 n_loads, n_lookups);
        $display("including %0d unsupported-format and %0d out-of-memory results",
                 n_unknown, n_faults);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
